// File: rtl/quaternion_to_euler_angles_assert.svh
// Assertion helpers used by the RTL; clk and rst are taken from the enclosing module.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// checked only outside reset
`define QTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define QTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/qte_pkg.sv
package qte_pkg;

  localparam int QW          = 16;  // quaternion component width
  localparam int OPW         = 34;  // atan2 operand width out of the product stages
  localparam int SW          = 32;  // saturated asin argument, Q.30
  localparam int RADW        = 61;  // 2^60 - s^2
  localparam int ROOTW       = 31;  // floor(sqrt(rad))
  localparam int SQRT_STAGES = 31;  // one root bit per stage
  localparam int REMW        = 33;
  localparam int CW          = 36;  // CORDIC x/y datapath
  localparam int ZW          = 27;  // angle, degrees * 65536
  localparam int ANG_TAB_LEN = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [QW-1:0] DECL_RESET = 16'sd411;

  localparam logic signed [ZW-1:0] ANG_90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] ANG_180 = ZW'(180 * 65536);

  // floor(n / 100) = (n * YAW_RECIP) >> YAW_RECIP_SH for n < 2^18
  localparam int YAW_NW       = 18;
  localparam int YAW_RECIPW   = 20;
  localparam logic [YAW_RECIPW-1:0] YAW_RECIP = 20'd671089;
  localparam int YAW_RECIP_SH = 26;

  typedef struct packed {
    logic signed [OPW-1:0] yaw_y;
    logic signed [OPW-1:0] yaw_x;
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic signed [SW-1:0]  s;
  } opnd_t;

  // atan(2^-i) in degrees * 65536, rounded
  function automatic logic [21:0] atan_q16(input int i);
    logic [21:0] r;
    case (i)
      0:  r = 22'd2949120;
      1:  r = 22'd1740967;
      2:  r = 22'd919879;
      3:  r = 22'd466945;
      4:  r = 22'd234379;
      5:  r = 22'd117304;
      6:  r = 22'd58666;
      7:  r = 22'd29335;
      8:  r = 22'd14668;
      9:  r = 22'd7334;
      10: r = 22'd3667;
      11: r = 22'd1833;
      12: r = 22'd917;
      13: r = 22'd458;
      14: r = 22'd229;
      15: r = 22'd115;
      16: r = 22'd57;
      17: r = 22'd29;
      18: r = 22'd14;
      19: r = 22'd7;
      20: r = 22'd4;
      21: r = 22'd2;
      22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/qte_front.sv
module qte_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [qte_pkg::QW-1:0] w,
  input  logic signed [qte_pkg::QW-1:0] x,
  input  logic signed [qte_pkg::QW-1:0] y,
  input  logic signed [qte_pkg::QW-1:0] z,
  output logic                         out_valid,
  output qte_pkg::opnd_t               opnd,
  output logic [qte_pkg::RADW-1:0]     rad
);
  import qte_pkg::*;

  logic [3:0] vld;

  // stage 1: products, Q2.30
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_wx, p_yz, p_xz, p_wy;

  // stage 2: sums and saturated asin argument
  opnd_t s2;
  logic signed [OPW-1:0] s_raw;
  logic signed [OPW-1:0] yaw_y_n, yaw_x_n, roll_y_n, roll_x_n;

  // stage 3: square
  opnd_t s3;
  logic [RADW-1:0] sq;
  logic [SW-2:0] s_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= w * w;
      p_xx <= x * x;
      p_yy <= y * y;
      p_zz <= z * z;
      p_xy <= x * y;
      p_wz <= w * z;
      p_wx <= w * x;
      p_yz <= y * z;
      p_xz <= x * z;
      p_wy <= w * y;
    end
  end

  always_comb begin
    yaw_y_n  = (OPW'(p_xy) + OPW'(p_wz)) <<< 1;
    roll_y_n = (OPW'(p_wx) + OPW'(p_yz)) <<< 1;
    yaw_x_n  = OPW'(p_ww) + OPW'(p_xx) - OPW'(p_yy) - OPW'(p_zz);
    roll_x_n = OPW'(p_ww) - OPW'(p_xx) - OPW'(p_yy) + OPW'(p_zz);
    s_raw    = (OPW'(p_xz) - OPW'(p_wy)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2.yaw_y  <= yaw_y_n;
      s2.yaw_x  <= yaw_x_n;
      s2.roll_y <= roll_y_n;
      s2.roll_x <= roll_x_n;
      if (s_raw > OPW'(64'sd1073741824)) begin
        s2.s <= SW'(64'sd1073741824);
      end else if (s_raw < -OPW'(64'sd1073741824)) begin
        s2.s <= -SW'(64'sd1073741824);
      end else begin
        s2.s <= s_raw[SW-1:0];
      end
    end
  end

  assign s_mag = s2.s[SW-1] ? (SW-1)'(-s2.s) : s2.s[SW-2:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= s2;
      sq <= RADW'(s_mag * s_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opnd <= s3;
      rad  <= (RADW'(1) << 60) - sq;
    end
  end

  assign out_valid = vld[3];

endmodule

// File: rtl/qte_isqrt.sv
module qte_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [qte_pkg::RADW-1:0]  rad,
  input  qte_pkg::opnd_t            side_in,
  output logic                      out_valid,
  output logic [qte_pkg::ROOTW-1:0] root,
  output qte_pkg::opnd_t            side_out
);
  import qte_pkg::*;

  logic [REMW-1:0]  rem   [0:SQRT_STAGES];
  logic [ROOTW-1:0] rt    [0:SQRT_STAGES];
  logic [2*SQRT_STAGES-1:0] rest [0:SQRT_STAGES];
  opnd_t            side  [0:SQRT_STAGES];
  logic             vld   [0:SQRT_STAGES];

  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign rest[0] = {1'b0, rad};
  assign side[0] = side_in;
  assign vld[0]  = in_valid;

  // digit by digit, one root bit per stage
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [REMW+1:0] rs, trial;
    logic            ge;

    assign rs    = {rem[k], rest[k][2*SQRT_STAGES-1 -: 2]};
    assign trial = {2'b00, rt[k], 2'b01};
    assign ge    = rs >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? REMW'(rs - trial) : REMW'(rs);
        rt[k+1]   <= {rt[k][ROOTW-2:0], ge};
        rest[k+1] <= {rest[k][2*SQRT_STAGES-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[SQRT_STAGES];
  assign root      = rt[SQRT_STAGES];
  assign side_out  = side[SQRT_STAGES];

endmodule

// File: rtl/qte_cordic.sv
module qte_cordic #(
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [qte_pkg::CW-1:0]  yi,
  input  logic signed [qte_pkg::CW-1:0]  xi,
  output logic                           out_valid,
  output logic signed [qte_pkg::ZW-1:0]  ang
);
  import qte_pkg::*;

  logic signed [CW-1:0] xs [0:STEPS];
  logic signed [CW-1:0] ys [0:STEPS];
  logic signed [ZW-1:0] zs [0:STEPS];
  logic                 fx [0:STEPS];
  logic                 vs [0:STEPS];

  logic signed [CW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;
  logic                 f0;

  // axis and left half-plane handling; fixed answers bypass the rotations
  always_comb begin
    x0 = xi;
    y0 = yi;
    z0 = '0;
    f0 = 1'b0;
    if (yi == '0) begin
      f0 = 1'b1;
      z0 = xi[CW-1] ? ANG_180 : '0;
    end else if (xi == '0) begin
      f0 = 1'b1;
      z0 = yi[CW-1] ? -ANG_90 : ANG_90;
    end else if (xi[CW-1]) begin
      x0 = -xi;
      y0 = -yi;
      z0 = yi[CW-1] ? -ANG_180 : ANG_180;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= x0;
      ys[0] <= y0;
      zs[0] <= z0;
      fx[0] <= f0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] da;

    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign da = $signed({{(ZW-22){1'b0}}, atan_q16(i)});

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fx[i+1] <= fx[i];
        if (!ys[i][CW-1]) begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= fx[i] ? zs[i] : zs[i] + da;
        end else begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= fx[i] ? zs[i] : zs[i] - da;
        end
      end
    end
  end

  assign out_valid = vs[STEPS];
  assign ang       = zs[STEPS];

endmodule

// File: rtl/qte_post.sv
module qte_post (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [qte_pkg::ZW-1:0] yaw_q,
  input  logic signed [qte_pkg::ZW-1:0] pitch_a,
  input  logic signed [qte_pkg::ZW-1:0] roll_q,
  input  logic signed [qte_pkg::QW-1:0] decl,
  output logic                          out_valid,
  output logic signed [9:0]             yaw_deg,
  output logic signed [7:0]             pitch_deg,
  output logic signed [8:0]             roll_deg
);
  import qte_pkg::*;

  localparam int FW = 35;
  localparam int PW = YAW_NW + YAW_RECIPW;

  logic [2:0] vld;

  logic signed [FW-1:0] yaw_full_n, yaw_full;
  logic signed [ZW:0]   pn, pn_adj, rn_adj;
  logic [7:0]           pitch1, pitch2;
  logic [8:0]           roll1, roll2;

  logic [FW-1:0]        mag;
  logic                 neg;
  logic [PW-1:0]        prod;
  logic [11:0]          q;

  always_comb begin
    yaw_full_n = FW'(yaw_q) * FW'(100) - $signed({{(FW-QW-16){decl[QW-1]}}, decl, 16'b0});
    pn         = -$signed({pitch_a[ZW-1], pitch_a});
    pn_adj     = pn + (pn[ZW] ? (ZW+1)'(65535) : '0);
    rn_adj     = (ZW+1)'(roll_q) + (roll_q[ZW-1] ? (ZW+1)'(65535) : '0);
    mag        = yaw_full[FW-1] ? FW'(-yaw_full) : FW'(yaw_full);
    q          = prod[PW-1 -: 12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_full <= yaw_full_n;
      pitch1   <= pn_adj[23:16];
      roll1    <= rn_adj[24:16];

      neg      <= yaw_full[FW-1];
      prod     <= mag[YAW_NW+15:16] * YAW_RECIP;
      pitch2   <= pitch1;
      roll2    <= roll1;

      yaw_deg   <= neg ? 10'(-q) : q[9:0];
      pitch_deg <= pitch2;
      roll_deg  <= roll2;
    end
  end

  assign out_valid = vld[2];

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// Quaternion to yaw / pitch / roll in whole degrees.
// Input channel: quat_w..quat_z (signed Q1.15) with in_valid / in_stall; a word is
// taken on a clock edge with in_valid high and in_stall low.
// Output channel: yaw_deg, pitch_deg, roll_deg with out_valid / out_stall; one
// result word for every input word, in order.
// Declination (hundredths of a degree) is written through cfg_wen / cfg_wdata and
// subtracted from yaw; it should only change while the pipeline is empty.
// Throughput: one word per cycle while the output is not stalled.
// Stages: 4 product/sum stages, 31 square-root stages (one root bit each),
// 1 + CORDIC_STEPS CORDIC stages and 3 output stages (declination, divide by
// reciprocal, output register).
// A stalled output freezes the whole pipeline in place and raises in_stall in the
// same cycle; nothing is dropped or repeated.
// Reset (rst, synchronous) empties the pipeline and sets the declination to 4.11.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [qte_pkg::QW-1:0] quat_w,
  input  logic signed [qte_pkg::QW-1:0] quat_x,
  input  logic signed [qte_pkg::QW-1:0] quat_y,
  input  logic signed [qte_pkg::QW-1:0] quat_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [9:0]             yaw_deg,
  output logic signed [7:0]             pitch_deg,
  output logic signed [8:0]             roll_deg,
  input  logic                          cfg_wen,
  input  logic signed [qte_pkg::QW-1:0] cfg_wdata
);
  import qte_pkg::*;
`include "quaternion_to_euler_angles_assert.svh"

  logic                 en;
  logic signed [QW-1:0] declination_centideg;

  logic                 f_valid;
  opnd_t                f_opnd;
  logic [RADW-1:0]      f_rad;

  logic                 r_valid;
  logic [ROOTW-1:0]     r_root;
  opnd_t                r_opnd;

  logic                 yaw_v, pitch_v, roll_v;
  logic signed [ZW-1:0] yaw_a, pitch_a, roll_a;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      declination_centideg <= DECL_RESET;
    end else if (cfg_wen) begin
      declination_centideg <= cfg_wdata;
    end
  end

  qte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .w         (quat_w),
    .x         (quat_x),
    .y         (quat_y),
    .z         (quat_z),
    .out_valid (f_valid),
    .opnd      (f_opnd),
    .rad       (f_rad)
  );

  qte_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .rad       (f_rad),
    .side_in   (f_opnd),
    .out_valid (r_valid),
    .root      (r_root),
    .side_out  (r_opnd)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .yi        (CW'(r_opnd.yaw_y)),
    .xi        (CW'(r_opnd.yaw_x)),
    .out_valid (yaw_v),
    .ang       (yaw_a)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .yi        (CW'(r_opnd.roll_y)),
    .xi        (CW'(r_opnd.roll_x)),
    .out_valid (roll_v),
    .ang       (roll_a)
  );

  // asin(s) as atan2(s, sqrt(1 - s^2))
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .yi        (CW'(r_opnd.s)),
    .xi        ($signed({{(CW-ROOTW){1'b0}}, r_root})),
    .out_valid (pitch_v),
    .ang       (pitch_a)
  );

  qte_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (yaw_v),
    .yaw_q     (yaw_a),
    .pitch_a   (pitch_a),
    .roll_q    (roll_a),
    .decl      (declination_centideg),
    .out_valid (out_valid),
    .yaw_deg   (yaw_deg),
    .pitch_deg (pitch_deg),
    .roll_deg  (roll_deg)
  );

  `QTE_ASSERT(a_lanes_aligned, (yaw_v == roll_v) && (yaw_v == pitch_v), "CORDIC lanes out of step")
  `QTE_ASSERT(a_stall_back, (out_valid && out_stall) |-> in_stall, "input taken while output held")
  `QTE_ASSERT(a_pitch_range, out_valid |-> (pitch_deg >= -8'sd90 && pitch_deg <= 8'sd90), "pitch out of range")
  `QTE_ASSERT(a_roll_range, out_valid |-> (roll_deg >= -9'sd180 && roll_deg <= 9'sd180), "roll out of range")
  `QTE_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result word present after reset")

endmodule

// File: sim/tb_quaternion_to_euler_angles.sv
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles;
  import qte_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int LATENCY = STEPS + 39;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint DEG = 65536;
  localparam longint Q30 = 64'sd1073741824;
  localparam longint ATAN_DEG_Q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  typedef struct packed {
    logic signed [9:0] yaw;
    logic signed [7:0] pitch;
    logic signed [8:0] roll;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [QW-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [9:0] yaw_deg;
  logic signed [7:0] pitch_deg;
  logic signed [8:0] roll_deg;
  logic cfg_wen = 1'b0;
  logic signed [QW-1:0] cfg_wdata = '0;

  logic signed [QW-1:0] decl = DECL_RESET;
  angles_t expected_angles[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  quaternion_to_euler_angles dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .yaw_deg(yaw_deg), .pitch_deg(pitch_deg), .roll_deg(roll_deg),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // vectoring CORDIC, angle in degrees * 65536
  function automatic longint atan2_deg_q16(longint y, longint x);
    longint ang, dx, dy;
    ang = 0;
    if (y == 0) return (x < 0) ? 180 * DEG : 0;
    if (x == 0) return (y > 0) ? 90 * DEG : -90 * DEG;
    if (x < 0) begin
      ang = (y > 0) ? 180 * DEG : -180 * DEG;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += ATAN_DEG_Q16[i];
      end else begin
        x -= dx; y += dy; ang -= ATAN_DEG_Q16[i];
      end
    end
    return ang;
  endfunction

  function automatic angles_t euler_of(longint w, longint x, longint y, longint z);
    longint s, yaw_q, pitch_q, roll_q, yaw_full;
    logic [63:0] c;
    angles_t a;
    yaw_q = atan2_deg_q16(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
    roll_q = atan2_deg_q16(2 * (w * x + y * z), w * w - x * x - y * y + z * z);
    s = 2 * (x * z - w * y);
    if (s > Q30) s = Q30;
    if (s < -Q30) s = -Q30;
    c = root_floor((64'd1 << 60) - 64'(s * s));
    pitch_q = -atan2_deg_q16(s, longint'(c));
    yaw_full = yaw_q * 100 - longint'(decl) * DEG;
    a.yaw = 10'(yaw_full / (100 * DEG));
    a.pitch = 8'(pitch_q / DEG);
    a.roll = 9'(roll_q / DEG);
    return a;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // expectation is logged at the edge the word is taken
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      expected_angles.push_back(euler_of(quat_w, quat_x, quat_y, quat_z));
  end

  always @(posedge clk) begin
    angles_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_angles.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (yaw_deg !== e.yaw) begin
          $error("yaw_deg expected %0d got %0d", e.yaw, yaw_deg);
          errors++;
        end
        if (pitch_deg !== e.pitch) begin
          $error("pitch_deg expected %0d got %0d", e.pitch, pitch_deg);
          errors++;
        end
        if (roll_deg !== e.roll) begin
          $error("roll_deg expected %0d got %0d", e.roll, roll_deg);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  task automatic send_unit_quat();
    real a, b, c, d, n;
    a = real'($urandom_range(0, 65535)) - 32768.0;
    b = real'($urandom_range(0, 65535)) - 32768.0;
    c = real'($urandom_range(0, 65535)) - 32768.0;
    d = real'($urandom_range(0, 65535)) - 32768.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) n = 1.0;
    send_quat(16'($rtoi(a * 32767.0 / n)), 16'($rtoi(b * 32767.0 / n)),
              16'($rtoi(c * 32767.0 / n)), 16'($rtoi(d * 32767.0 / n)));
  endtask

  task automatic send_any_quat();
    if ($urandom_range(0, 3) == 0)
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      send_unit_quat();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_angles.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_declination(logic signed [15:0] v);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    decl = v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic test_directed();
    send_quat(0, 0, 0, 0);
    send_quat(16'sd32767, 0, 0, 0);
    send_quat(-16'sd32768, 0, 0, 0);
    send_quat(0, 16'sd32767, 0, 0);
    send_quat(0, 0, 16'sd32767, 0);
    send_quat(0, 0, 0, 16'sd32767);
    send_quat(0, 0, 0, -16'sd32768);
    send_quat(16'sd23170, 0, 16'sd23170, 0);   // pitch at +90
    send_quat(16'sd23170, 0, -16'sd23170, 0);  // pitch at -90
    send_quat(-16'sd32768, 0, 16'sd32767, 0);  // asin argument saturates
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd23170, 0, 0, 16'sd23170);   // yaw on the +90 axis
    send_quat(16'sd23170, 16'sd23170, 0, 0);
    send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
    send_quat(16'sd100, 0, 0, -16'sd32000);    // negative x, yaw near -180
    send_quat(16'sd100, 0, 0, 16'sd32000);
    send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
  endtask

  task automatic test_declination();
    logic signed [15:0] settings [0:5];
    settings = '{16'sd18000, -16'sd18000, 16'sd0, 16'sd32767, -16'sd32768, 16'sd411};
    foreach (settings[k]) begin
      write_declination(settings[k]);
      send_quat(0, 0, 0, 0);
      send_quat(16'sd100, 0, 0, -16'sd32000);
      repeat (20) send_any_quat();
    end
    write_declination(16'($urandom_range(0, 36000) - 18000));
    repeat (20) send_any_quat();
  endtask

  task automatic test_random();
    repeat (480) send_any_quat();
    drain();  // sender holds off until the pipeline is empty
    repeat (150) send_any_quat();
    quiet = 1'b1;
    repeat (100) send_any_quat();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_declination();
    test_random();
    in_valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
